// ===== rtl/arw_pkg.sv =====
// ============================================================================
// arw_pkg: shared types and constants for the anti-replay window
// Item structs for both channels, status codes, operation codes and the
// window size.
// ============================================================================
package arw_pkg;

    // Number of packet numbers covered by the window (1 to 64).
    localparam int WINDOW = 64;

    // Bitmap position that stands for the highest accepted packet number.
    localparam logic [5:0] TOP_POS = 6'd63;

    // Operation codes carried in the op field.
    localparam logic OP_CHECK = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Status codes reported with every result word.
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_SEQ    = 3'd1;
    localparam logic [2:0] ST_REPLAY = 3'd2;
    localparam logic [2:0] ST_OLD    = 3'd3;
    localparam logic [2:0] ST_AUTH   = 3'd4;
    localparam logic [2:0] ST_RESET  = 3'd5;

    typedef struct packed {
        logic        op;
        logic [63:0] pkt_number;
        logic [31:0] hdr_sequence;
        logic        auth_ok;
    } in_item_t;

    typedef struct packed {
        logic        accepted;
        logic [2:0]  status;
        logic [63:0] highest_seen;
    } out_item_t;

endpackage

// ===== rtl/anti_replay_window_core.sv =====
// ============================================================================
// anti_replay_window_core: sliding anti-replay window for a tunnel receiver
// Checks each packet number against a 64-entry window anchored at the
// highest accepted number, and commits passing packets to the window.
// ============================================================================
//
// Usage:
//   Packet words enter on the pkt channel (pkt_valid / pkt_ready / pkt) and
//   every word produces exactly one result word on the res channel
//   (res_valid / res_ready / res). A word with op = OP_CHECK is checked for a
//   sequence mismatch, then for age and replay against the window, then for
//   failed authentication; a packet that passes is committed. A word with
//   op = OP_CLEAR empties the window, as done on a key swap.
//
//   An accepted word passes through two registers, first the input register
//   and then the result register, before its result word appears. Throughput is
//   one word per cycle while the receiver does not stall, set by the window update
//   (64-bit compare, subtract and barrel shift) that feeds straight back into the window registers.
//
//   Reset clears the highest number and the bitmap and empties both stages.
//   When the receiver stalls, the result word holds, the input register
//   still fills, and pkt_ready drops only once both stages are occupied.
//
module anti_replay_window_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pkt_valid,
    output logic                pkt_ready,
    input  arw_pkg::in_item_t   pkt,
    output logic                res_valid,
    input  logic                res_ready,
    output arw_pkg::out_item_t  res
);

    // Input stage.
    logic               s1_valid_reg;
    arw_pkg::in_item_t  s1_item_reg;

    // Window state.
    logic [63:0]        top_number_reg;
    logic [63:0]        top_number_next;
    logic [63:0]        seen_bits_reg;
    logic [63:0]        seen_bits_next;

    // Result stage.
    logic               res_valid_reg;
    arw_pkg::out_item_t res_reg;
    arw_pkg::out_item_t res_next;

    logic               advance;
    logic               seq_ok;
    logic               newer;
    logic [63:0]        dist_up;
    logic [63:0]        dist_down;
    logic               jump_full;
    logic               too_old;
    logic [5:0]         bit_pos;
    logic               bit_seen;
    logic               accept_pkt;

    // The input word moves into the result stage whenever the result
    // register is empty or is being drained in this same cycle.
    assign advance   = s1_valid_reg && (!res_valid_reg || res_ready);
    assign pkt_ready = !s1_valid_reg || advance;

    // Window arithmetic on the registered word.
    assign seq_ok    = (s1_item_reg.pkt_number[31:0] == s1_item_reg.hdr_sequence);
    assign newer     = (s1_item_reg.pkt_number > top_number_reg);
    assign dist_up   = s1_item_reg.pkt_number - top_number_reg;
    assign dist_down = top_number_reg - s1_item_reg.pkt_number;
    assign jump_full = (dist_up >= 64'(arw_pkg::WINDOW));
    assign too_old   = (s1_item_reg.pkt_number == 64'd0)
                    || (dist_down >= 64'(arw_pkg::WINDOW));

    // Bit 63 stands for the highest number; older numbers sit lower.
    assign bit_pos   = arw_pkg::TOP_POS - dist_down[5:0];
    assign bit_seen  = seen_bits_reg[bit_pos];

    always_comb
    begin
        top_number_next       = top_number_reg;
        seen_bits_next        = seen_bits_reg;
        accept_pkt            = 1'b0;
        res_next.accepted     = 1'b0;
        res_next.status       = arw_pkg::ST_OK;

        if (s1_item_reg.op == arw_pkg::OP_CLEAR)
        begin
            top_number_next = 64'd0;
            seen_bits_next  = 64'd0;
            res_next.status = arw_pkg::ST_RESET;
        end
        else if (!seq_ok)
        begin
            res_next.status = arw_pkg::ST_SEQ;
        end
        else if (newer)
        begin
            if (!s1_item_reg.auth_ok)
            begin
                res_next.status = arw_pkg::ST_AUTH;
            end
            else
            begin
                accept_pkt      = 1'b1;
                top_number_next = s1_item_reg.pkt_number;
                if (jump_full)
                begin
                    seen_bits_next = 64'd1 << arw_pkg::TOP_POS;
                end
                else
                begin
                    seen_bits_next = (seen_bits_reg >> dist_up[5:0])
                                   | (64'd1 << arw_pkg::TOP_POS);
                end
            end
        end
        else if (too_old)
        begin
            res_next.status = arw_pkg::ST_OLD;
        end
        else if (bit_seen)
        begin
            res_next.status = arw_pkg::ST_REPLAY;
        end
        else if (!s1_item_reg.auth_ok)
        begin
            res_next.status = arw_pkg::ST_AUTH;
        end
        else
        begin
            accept_pkt     = 1'b1;
            seen_bits_next = seen_bits_reg | (64'd1 << bit_pos);
        end

        res_next.accepted     = accept_pkt;
        res_next.highest_seen = top_number_next;
    end

    // Control and window state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
            top_number_reg <= 64'd0;
            seen_bits_reg  <= 64'd0;
        end
        else
        begin
            if (pkt_ready)
            begin
                s1_valid_reg <= pkt_valid;
            end
            if (advance)
            begin
                res_valid_reg  <= 1'b1;
                top_number_reg <= top_number_next;
                seen_bits_reg  <= seen_bits_next;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (pkt_ready && pkt_valid)
        begin
            s1_item_reg <= pkt;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== rtl/arw_checker.sv =====
// ============================================================================
// arw_checker: port-level assertions for the anti-replay window
// Watches the packet and result channels of the core and is bound to it.
// ============================================================================
module arw_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               pkt_valid,
    input logic               pkt_ready,
    input arw_pkg::in_item_t  pkt,
    input logic               res_valid,
    input logic               res_ready,
    input arw_pkg::out_item_t res
);

    // A stalled result word must hold.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result word changed while stalled");

    // A window clear always reports an empty window.
    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status == arw_pkg::ST_RESET
        |-> !res.accepted && res.highest_seen == 64'd0)
        else $error("clear word reported a nonempty window");

    // The accepted flag and the ok status go together.
    a_accept_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.accepted == (res.status == arw_pkg::ST_OK))
        else $error("accepted flag disagrees with status");

    // A clear word entering an empty pipeline passes the input and result registers and yields ST_RESET.
    a_clear_latency: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid && pkt_ready && pkt.op == arw_pkg::OP_CLEAR && !res_valid
        ##1 !res_valid |=> res_valid && res.status == arw_pkg::ST_RESET)
        else $error("clear word did not appear after two cycles");

endmodule

bind anti_replay_window_core arw_checker u_arw_checker (.*);
